>>> rtl/core/met_pkg.sv
package met_pkg;

    // default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 28;

    // register indexes of the configuration port
    localparam logic CFG_MAX_ITER = 1'b0;
    localparam logic CFG_LIMIT    = 1'b1;

    localparam int unsigned MAX_ITER_RST = 255;
    localparam int unsigned LIMIT_RST    = 268435456;

    // saturation bounds of the 32-bit value format
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_HI  = 64'sd2147483647;
    localparam logic signed [63:0] S64_LO  = -64'sd2147483648;
    localparam logic signed [33:0] S34_HI  = 34'sd2147483647;
    localparam logic signed [33:0] S34_LO  = -34'sd2147483648;

    // input beat: point c
    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } t_point;

    // output beat
    typedef struct packed {
        logic [7:0] gray_level;
        logic       escaped;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic escape;
        logic last;
        logic out_free;
    } t_sts;

    // floor shift of a product, clamped to the 32-bit range
    function automatic logic signed [31:0] sat_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic signed [63:0] s;
        s = v >>> sh;
        if (s > S64_HI) begin
            return S32_MAX;
        end else if (s < S64_LO) begin
            return S32_MIN;
        end else begin
            return s[31:0];
        end
    endfunction

    // clamp a sum of up to three terms to the 32-bit range
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > S34_HI) begin
            return S32_MAX;
        end else if (v < S34_LO) begin
            return S32_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

>>> rtl/core/met_chan_if.sv
interface met_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/met_ctrl.sv
module met_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  met_pkg::t_sts i_sts,
    output met_pkg::t_cmd o_cmd
);
    import met_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (i_sts.escape || i_sts.last) begin
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_UPD: begin
                if (i_sts.escape || i_sts.last) begin
                    o_cmd.fin = i_sts.out_free;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // an accepted point always starts a multiply
    a_load_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && i_in_valid |=> (r_state == ST_MUL))
        else $error("accepted point did not start the multiply");

    // a result is only written into a free output slot
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_sts.out_free)
        else $error("result written over an untaken beat");

    // an update and a finish never share a cycle
    a_step_or_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.step && o_cmd.fin))
        else $error("update and finish in the same cycle");

endmodule

>>> rtl/core/met_dp.sv
module met_dp #(
    parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  met_pkg::t_cmd      i_cmd,
    output met_pkg::t_sts      o_sts,
    input  logic signed [31:0] i_c_real,
    input  logic signed [31:0] i_c_imag,
    input  logic [7:0]         i_max_iter,
    input  logic [30:0]        i_limit,
    met_chan_if.source         o_res
);
    import met_pkg::*;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [63:0] r_pxx;
    logic signed [63:0] r_pyy;
    logic signed [63:0] r_pxy;
    logic [7:0]         r_iter;
    logic               r_out_valid;
    t_result            r_out;

    logic signed [31:0] w_sxx;
    logic signed [31:0] w_syy;
    logic signed [31:0] w_sxy;
    logic [32:0]        w_mag;
    logic signed [33:0] w_nx_sum;
    logic signed [33:0] w_ny_sum;
    logic               w_escape;
    logic               w_out_free;

    // scale and clamp the squared terms
    always_comb begin
        w_sxx    = sat_shr(r_pxx, FRAC_BITS);
        w_syy    = sat_shr(r_pyy, FRAC_BITS);
        w_sxy    = sat_shr(r_pxy, FRAC_BITS - 1);
        w_mag    = {1'b0, w_sxx} + {1'b0, w_syy};
        w_nx_sum = 34'(w_sxx) - 34'(w_syy) + 34'(r_cr);
        w_ny_sum = 34'(w_sxy) + 34'(r_ci);
    end

    // the products in hand are of the z from the last update; at z = 0 the
    // magnitude is zero and never exceeds the limit
    assign w_escape   = w_mag > {2'b00, i_limit};
    assign w_out_free = !r_out_valid || o_res.ready;

    assign o_sts.escape   = w_escape;
    assign o_sts.last     = (r_iter == i_max_iter);
    assign o_sts.out_free = w_out_free;

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= '0;
            r_y    <= '0;
            r_cr   <= i_c_real;
            r_ci   <= i_c_imag;
            r_iter <= '0;
        end else if (i_cmd.step) begin
            r_x    <= sat34(w_nx_sum);
            r_y    <= sat34(w_ny_sum);
            r_iter <= r_iter + 8'd1;
        end
    end

    // shared multiply stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pxx <= r_x * r_x;
            r_pyy <= r_y * r_y;
            r_pxy <= r_x * r_y;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.gray_level <= w_escape ? 8'(r_iter - 8'd1) : 8'd0;
            r_out.escaped    <= w_escape;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // an update never runs past the iteration budget
    a_step_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_iter < i_max_iter))
        else $error("update past the iteration budget");

    // escape is only seen after at least one update
    a_escape_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin && w_escape |-> (r_iter != 8'd0))
        else $error("escape reported before any update");

    // reported escape level stays below the maximum budget
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.escaped |-> (o_res.data.gray_level != 8'd255))
        else $error("escape level out of range");

endmodule

>>> rtl/core/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time evaluator: takes one point c in signed fixed point
// (FRAC_BITS fraction bits, Q4.28 by default), iterates z = z*z + c from zero
// up to max_iterations times with saturating arithmetic, and returns the index
// of the first iteration whose |z|^2 exceeds escape_limit_sq (escaped = 1), or
// level 0 with escaped = 0. One point is in work at a time, in an iteration loop
// of one registered multiply stage (three 32x32 products) followed by one
// saturate-and-update step. The result sits in an output register, so the
// next point is accepted while it waits to be taken.
module mandelbrot_escape_time_top #(
    parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    met_chan_if.sink    i_pt,
    met_chan_if.source  o_res
);
    import met_pkg::*;

    logic [7:0]  r_max_iter;
    logic [30:0] r_limit;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= 8'(MAX_ITER_RST);
            r_limit    <= 31'(LIMIT_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data;
                default:      r_limit    <= r_limit;
            endcase
        end
    end

    assign i_pt.ready = w_in_ready;

    met_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    met_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_c_real   (i_pt.data.c_real),
        .i_c_imag   (i_pt.data.c_imag),
        .i_max_iter (r_max_iter),
        .i_limit    (r_limit),
        .o_res      (o_res)
    );

endmodule

>>> tb/mandelbrot_escape_time_top_test.sv
module mandelbrot_escape_time_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    // a few Q4.28 values
    localparam logic [31:0] Q_ONE     = 32'h1000_0000;
    localparam logic [31:0] Q_TWO     = 32'h2000_0000;
    localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
    localparam logic [30:0] LIM_FOUR  = 31'h4000_0000;
    localparam logic [30:0] LIM_TOP   = 31'h7FFF_FFFF;

    // how long the result side holds off once the block has to fill up
    localparam int HOLD_CYCLES = 2000;
    // settling wait at the end, covering the longest point of 255 updates
    localparam int SETTLE_CYCLES = 520;

    // kinds of random points
    typedef enum {
        PK_NEAR,
        PK_FULL,
        PK_TINY,
        PK_MIX
    } t_pick;

    // a point with the level it should produce
    typedef struct {
        t_point  pt;
        t_result res;
    } t_pending_level;

    // escape level predictor and store of levels still owed by the block
    class escape_level_book;
        int unsigned      iter_limit;
        logic [30:0]      limit_sq;
        t_pending_level   levels_q[$];
        int               errors;

        function new();
            iter_limit = MAX_ITER_RST;
            limit_sq   = 31'(LIMIT_RST);
            errors     = 0;
        endfunction

        function void write_reg(input logic idx, input logic [30:0] data);
            if (idx == CFG_MAX_ITER) begin
                iter_limit = data[7:0];
            end else begin
                limit_sq = data;
            end
        endfunction

        function logic signed [63:0] clamp32(input logic signed [63:0] v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end else if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // iterate z = z*z + c from zero and find the first escaping update
        function t_result predict_level(input t_point p);
            logic signed [63:0] x, y, xx, yy, xy2, mx, my, cr, ci, lim64;
            t_result r;
            cr    = p.c_real;
            ci    = p.c_imag;
            lim64 = {33'd0, limit_sq};
            x     = '0;
            y     = '0;
            r     = '0;
            for (int k = 0; k < iter_limit; k++) begin
                xx  = clamp32((x * x) >>> FRAC);
                yy  = clamp32((y * y) >>> FRAC);
                xy2 = clamp32((x * y) >>> (FRAC - 1));
                x   = clamp32(xx - yy + cr);
                y   = clamp32(xy2 + ci);
                mx  = clamp32((x * x) >>> FRAC);
                my  = clamp32((y * y) >>> FRAC);
                if (mx + my > lim64) begin
                    r.gray_level = 8'(k);
                    r.escaped    = 1'b1;
                    break;
                end
            end
            return r;
        endfunction

        function void note_point(input t_point p);
            t_pending_level e;
            e.pt  = p;
            e.res = predict_level(p);
            levels_q.push_back(e);
        endfunction

        function int pending();
            return levels_q.size();
        endfunction

        task report_mismatch(input string msg);
            if (errors < 40) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endtask

        // compare one result beat with the oldest owed level
        task check_result(input t_result r);
            t_pending_level e;
            if (levels_q.size() == 0) begin
                report_mismatch($sformatf("result beat (level %0d, escaped %0b) with no point",
                                          r.gray_level, r.escaped));
                return;
            end
            e = levels_q.pop_front();
            if (r.gray_level !== e.res.gray_level) begin
                report_mismatch($sformatf("point %h,%h gray_level %0d, want %0d",
                                          e.pt.c_real, e.pt.c_imag,
                                          r.gray_level, e.res.gray_level));
            end
            if (r.escaped !== e.res.escaped) begin
                report_mismatch($sformatf("point %h,%h escaped %0b, want %0b",
                                          e.pt.c_real, e.pt.c_imag,
                                          r.escaped, e.res.escaped));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [30:0] i_cfg_data;

    met_chan_if #(.T(t_point))  pt_if ();
    met_chan_if #(.T(t_result)) res_if ();

    escape_level_book book;
    bit idle_on;
    bit hold_req;

    mandelbrot_escape_time_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_point mk_point(input logic [31:0] re, input logic [31:0] im);
        t_point p;
        p.c_real = re;
        p.c_imag = im;
        return p;
    endfunction

    // random point of the given kind
    function automatic t_point draw_point(input t_pick kind);
        t_pick k;
        int    roll;
        k = kind;
        if (k == PK_MIX) begin
            roll = $urandom_range(0, 9);
            k = (roll < 5) ? PK_NEAR : (roll < 8) ? PK_FULL : PK_TINY;
        end
        case (k)
            PK_NEAR: begin
                // real in [-2.5, 1.0], imag in [-1.5, 1.5]
                return mk_point(32'($urandom_range(0, 939524096)) - 32'd671088640,
                                32'($urandom_range(0, 805306368)) - 32'd402653184);
            end
            PK_TINY: begin
                return mk_point(32'($urandom_range(0, 255)) - 32'd128,
                                32'($urandom_range(0, 255)) - 32'd128);
            end
            default: begin
                return mk_point($urandom, $urandom);
            end
        endcase
    endfunction

    // offer one point, wait for its beat, then idle for a random gap, which may be empty
    task automatic offer_point(input t_point p);
        int gap;
        pt_if.valid <= 1'b1;
        pt_if.data  <= p;
        do begin
            @(posedge i_clk);
        end while (!(pt_if.valid && pt_if.ready));
        book.note_point(p);
        gap = pick_gap();
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_points(input int n, input t_pick kind);
        for (int i = 0; i < n; i++) begin
            offer_point(draw_point(kind));
        end
    endtask

    // stop offering and wait until every owed level has come back
    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // write both registers while the block is idle
    task automatic load_regs(input logic [7:0] iters, input logic [30:0] lim);
        logic [30:0] word;
        word = {23'($urandom), iters};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_ITER;
        i_cfg_data <= word;
        @(posedge i_clk);
        book.write_reg(CFG_MAX_ITER, word);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        book.write_reg(CFG_LIMIT, lim);
        i_cfg_we   <= 1'b0;
    endtask

    // result side: check beats and drive ready with random stalls
    initial begin : result_sink
        int stall_left;
        int roll;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                book.check_result(res_if.data);
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on) begin
                roll = $urandom_range(0, 99);
                if (roll < 20) begin
                    stall_left = $urandom_range(1, 3);
                end else if (roll < 23) begin
                    stall_left = $urandom_range(15, 60);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : point_source
        logic [7:0]  iters;
        logic [30:0] lim;
        book         = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MAX_ITER;
        i_cfg_data   = '0;
        pt_if.valid  = 1'b0;
        pt_if.data   = '0;
        res_if.ready = 1'b0;
        idle_on      = 1'b0;
        hold_req     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points under the reset settings (255 updates, limit 1.0)
        offer_point(mk_point(32'h0, 32'h0));
        offer_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        offer_point(mk_point(32'h8000_0000, 32'h8000_0000));
        offer_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000));
        offer_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF));
        offer_point(mk_point(32'h7FFF_FFFF, 32'h0));
        offer_point(mk_point(32'h0, 32'h8000_0000));
        offer_point(mk_point(Q_ONE, 32'h0));
        // points in and around the set; only some of them escape at the first update
        offer_point(mk_point(-Q_TWO, 32'h0));
        offer_point(mk_point(-Q_ONE, 32'h0));
        offer_point(mk_point(Q_QUARTER, 32'h0));
        offer_point(mk_point(32'h0, Q_ONE));
        offer_point(mk_point(32'hF400_0000, 32'h0199_999A));
        offer_point(mk_point(32'h04CC_CCCD, 32'h0800_0000));
        offer_point(mk_point(32'h1, 32'h1));
        offer_point(mk_point(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait_drained();

        // usual limit 4.0, full iteration count; long result hold-off midway
        load_regs(8'd255, LIM_FOUR);
        for (int i = 0; i < 300; i++) begin
            if (i == 100) begin
                idle_on = 1'b1;
            end
            if (i == 150) begin
                hold_req = 1'b1;
            end
            offer_point(draw_point(i % 5 == 0 ? PK_MIX : PK_NEAR));
        end
        wait_drained();

        // no updates at all
        load_regs(8'd0, 31'($urandom));
        run_points(60, PK_MIX);
        wait_drained();

        // one update, zero limit
        load_regs(8'd1, 31'd0);
        run_points(60, PK_MIX);
        wait_drained();

        // largest limit, saturation territory
        load_regs(8'd255, LIM_TOP);
        run_points(60, PK_MIX);
        wait_drained();

        // random settings
        for (int s = 0; s < 4; s++) begin
            iters = (s == 1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 40));
            lim   = $urandom_range(0, 1) ? 31'($urandom)
                                         : 31'($urandom_range(32'h0400_0000, 32'h4000_0000));
            load_regs(iters, lim);
            run_points(90, PK_MIX);
            wait_drained();
        end

        // mid iteration count, limit 4.0
        load_regs(8'd128, LIM_FOUR);
        run_points(60, PK_NEAR);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
